### src/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg: shared types and codes of the posting list
// Entry layout, request codes, codes of the shared arithmetic unit and the
// request and response structs that travel between sequencer and unit.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int ID_W         = 16;
  localparam int CNT_W        = 16;
  localparam int SUM_W        = 32;
  localparam int TOTAL_W      = 9;
  localparam int REQ_W        = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam int ALU_OP_W = 3;
  localparam logic [ALU_OP_W-1:0] ALU_NOP    = 3'd0;
  localparam logic [ALU_OP_W-1:0] ALU_EQ     = 3'd1;
  localparam logic [ALU_OP_W-1:0] ALU_LT     = 3'd2;
  localparam logic [ALU_OP_W-1:0] ALU_ADDSAT = 3'd3;
  localparam logic [ALU_OP_W-1:0] ALU_ADD    = 3'd4;
  localparam logic [ALU_OP_W-1:0] ALU_SUB    = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [ALU_OP_W-1:0] op;
    logic [SUM_W-1:0]    a;
    logic [SUM_W-1:0]    b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

### src/posting_list_by_frequency.sv
// ----------------------------------------------------------------------------
// posting_list_by_frequency: count-ordered posting list of one term
// Sequencer over an entry memory with one read and one write port and a shared compare/add unit.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its result is
// loaded into the output register. Every step over the table is a memory read
// followed by a compare or a write: the id search reads and compares each
// entry scanned, a removal reads and writes each entry moved down, and a
// placement reads and compares each entry scanned, then reads and writes each
// entry moved up. Each entry needs its own read, as the memory has one read
// port. Reset clears the state, the entry count, the occurrence total and the
// output valid, so the block is idle and ready once reset is released.
module posting_list_by_frequency #(
  parameter int CAPACITY = plf_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [plf_pkg::REQ_W-1:0]   in_req_type,
  input  logic [plf_pkg::ID_W-1:0]    in_doc_id,
  input  logic [plf_pkg::CNT_W-1:0]   in_add_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [plf_pkg::ID_W-1:0]    out_found_id,
  output logic [plf_pkg::CNT_W-1:0]   out_found_count,
  output logic                        out_hit,
  output logic                        out_list_full,
  output logic [plf_pkg::TOTAL_W-1:0] out_doc_total,
  output logic [plf_pkg::SUM_W-1:0]   out_occurrence_total
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_SRD  = 4'd1;
  localparam logic [ST_W-1:0] S_SCHK = 4'd2;
  localparam logic [ST_W-1:0] S_DEC  = 4'd3;
  localparam logic [ST_W-1:0] S_SUB  = 4'd4;
  localparam logic [ST_W-1:0] S_RRD  = 4'd5;
  localparam logic [ST_W-1:0] S_RWR  = 4'd6;
  localparam logic [ST_W-1:0] S_PRD  = 4'd7;
  localparam logic [ST_W-1:0] S_PCHK = 4'd8;
  localparam logic [ST_W-1:0] S_MRD  = 4'd9;
  localparam logic [ST_W-1:0] S_MWR  = 4'd10;
  localparam logic [ST_W-1:0] S_PWR  = 4'd11;
  localparam logic [ST_W-1:0] S_ADD  = 4'd12;
  localparam logic [ST_W-1:0] S_DONE = 4'd13;

  logic [ST_W-1:0]              state_r, state_nxt;
  logic [plf_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [plf_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [plf_pkg::CNT_W-1:0]    add_r, add_nxt;
  logic [plf_pkg::CNT_W-1:0]    newc_r, newc_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                used_r, used_nxt;
  logic [plf_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  plf_pkg::entry_t              ent_r, ent_nxt;
  logic                         found_r, found_nxt;
  logic                         full_r, full_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [plf_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [plf_pkg::CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic                         out_full_r, out_full_nxt;
  logic [plf_pkg::TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic [plf_pkg::SUM_W-1:0]    out_sum_r, out_sum_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  plf_pkg::entry_t              mem_wdata;
  logic [AW-1:0]                mem_raddr;
  plf_pkg::entry_t              mem_rdata;

  plf_pkg::alu_req_t            alu_req;
  plf_pkg::alu_rsp_t            alu_rsp;

  logic [CW-1:0]                idx_inc;
  logic [CW-1:0]                idx_dec;
  logic [31:0]                  used_ext;
  logic                         req_known;
  logic                         req_reads;

  plf_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  plf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign used_ext  = 32'(used_r);
  assign req_reads = (req_r == plf_pkg::REQ_LOOKUP) || (req_r == plf_pkg::REQ_DELETE);
  assign req_known = req_reads || (req_r == plf_pkg::REQ_INSERT);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    add_nxt       = add_r;
    newc_nxt      = newc_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    used_nxt      = used_r;
    sum_nxt       = sum_r;
    ent_nxt       = ent_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_cnt_nxt   = out_cnt_r;
    out_hit_nxt   = out_hit_r;
    out_full_nxt  = out_full_r;
    out_total_nxt = out_total_r;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    alu_req       = '{op: plf_pkg::ALU_NOP, a: '0, b: '0};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          id_nxt    = in_doc_id;
          add_nxt   = in_add_count;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_SRD;
        end
      end
      // id search
      S_SRD: begin
        if (idx_r < used_r) begin
          mem_raddr = idx_r[AW-1:0];
          state_nxt = S_SCHK;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_SCHK: begin
        alu_req = '{op: plf_pkg::ALU_EQ, a: plf_pkg::SUM_W'(mem_rdata.id),
                    b: plf_pkg::SUM_W'(id_r)};
        if (alu_rsp.flag) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          ent_nxt   = mem_rdata;
          state_nxt = S_DEC;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end
      end
      S_DEC: begin
        if (req_r == plf_pkg::REQ_INSERT) begin
          if (found_r) begin
            alu_req   = '{op: plf_pkg::ALU_ADDSAT, a: plf_pkg::SUM_W'(ent_r.count),
                          b: plf_pkg::SUM_W'(add_r)};
            newc_nxt  = alu_rsp.res[plf_pkg::CNT_W-1:0];
            state_nxt = S_SUB;
          end else if (used_r >= CAP_V) begin
            full_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            newc_nxt  = add_r;
            idx_nxt   = '0;
            state_nxt = S_PRD;
          end
        end else if (req_r == plf_pkg::REQ_DELETE && found_r) begin
          state_nxt = S_SUB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SUB: begin
        alu_req   = '{op: plf_pkg::ALU_SUB, a: sum_r, b: plf_pkg::SUM_W'(ent_r.count)};
        sum_nxt   = alu_rsp.res;
        idx_nxt   = pos_r;
        state_nxt = S_RRD;
      end
      // close the gap left by the removed entry
      S_RRD: begin
        if (idx_inc < used_r) begin
          mem_raddr = idx_inc[AW-1:0];
          state_nxt = S_RWR;
        end else begin
          used_nxt = used_r - 1'b1;
          if (req_r == plf_pkg::REQ_INSERT) begin
            idx_nxt   = '0;
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_RRD;
      end
      // find the slot ahead of the first count not smaller
      S_PRD: begin
        if (idx_r < used_r) begin
          mem_raddr = idx_r[AW-1:0];
          state_nxt = S_PCHK;
        end else begin
          pos_nxt   = idx_r;
          state_nxt = S_MRD;
        end
      end
      S_PCHK: begin
        alu_req = '{op: plf_pkg::ALU_LT, a: plf_pkg::SUM_W'(mem_rdata.count),
                    b: plf_pkg::SUM_W'(newc_r)};
        if (alu_rsp.flag) begin
          idx_nxt   = idx_inc;
          state_nxt = S_PRD;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = used_r;
          state_nxt = S_MRD;
        end
      end
      // open the slot by moving the tail up
      S_MRD: begin
        if (idx_r > pos_r) begin
          mem_raddr = idx_dec[AW-1:0];
          state_nxt = S_MWR;
        end else begin
          state_nxt = S_PWR;
        end
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_dec;
        state_nxt = S_MRD;
      end
      S_PWR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = '{id: id_r, count: newc_r};
        used_nxt  = used_r + 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        alu_req   = '{op: plf_pkg::ALU_ADD, a: sum_r, b: plf_pkg::SUM_W'(newc_r)};
        sum_nxt   = alu_rsp.res;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = (req_reads && found_r) ? ent_r.id : '0;
          out_cnt_nxt   = (req_reads && found_r) ? ent_r.count : '0;
          out_hit_nxt   = req_known && found_r;
          out_full_nxt  = full_r;
          out_total_nxt = used_ext[plf_pkg::TOTAL_W-1:0];
          out_sum_nxt   = sum_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    id_r        <= id_nxt;
    add_r       <= add_nxt;
    newc_r      <= newc_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    ent_r       <= ent_nxt;
    found_r     <= found_nxt;
    full_r      <= full_nxt;
    out_id_r    <= out_id_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_hit_r   <= out_hit_nxt;
    out_full_r  <= out_full_nxt;
    out_total_r <= out_total_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_found_id         = out_id_r;
  assign out_found_count      = out_cnt_r;
  assign out_hit              = out_hit_r;
  assign out_list_full        = out_full_r;
  assign out_doc_total        = out_total_r;
  assign out_occurrence_total = out_sum_r;

  // entry count stays within the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CAP_V)
    else $error("entry count beyond capacity");

  // a transfer in starts a busy period
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("not busy after input transfer");

  // a dropped insert is never a merge
  a_full_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_list_full))
    else $error("hit and list_full together");

  // a returned count only comes from a found entry
  a_count_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_count != '0) |-> out_hit)
    else $error("found_count without hit");

endmodule

### src/plf_mem.sv
// ----------------------------------------------------------------------------
// plf_mem: entry storage
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module plf_mem #(
  parameter int DEPTH = plf_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  plf_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output plf_pkg::entry_t          rdata
);

  plf_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/plf_alu.sv
// ----------------------------------------------------------------------------
// plf_alu: shared compare and add unit
// Id equality, count compare, saturating count add and total add/subtract.
// ----------------------------------------------------------------------------
module plf_alu (
  input  plf_pkg::alu_req_t req,
  output plf_pkg::alu_rsp_t rsp
);

  logic [plf_pkg::CNT_W:0] sat_sum;

  always_comb begin
    sat_sum  = {1'b0, req.a[plf_pkg::CNT_W-1:0]} + {1'b0, req.b[plf_pkg::CNT_W-1:0]};
    rsp.res  = '0;
    rsp.flag = 1'b0;
    case (req.op)
      plf_pkg::ALU_EQ: begin
        rsp.flag = (req.a[plf_pkg::ID_W-1:0] == req.b[plf_pkg::ID_W-1:0]);
      end
      plf_pkg::ALU_LT: begin
        rsp.flag = (req.a < req.b);
      end
      plf_pkg::ALU_ADDSAT: begin
        if (sat_sum[plf_pkg::CNT_W]) begin
          rsp.res = plf_pkg::SUM_W'({plf_pkg::CNT_W{1'b1}});
        end else begin
          rsp.res = plf_pkg::SUM_W'(sat_sum[plf_pkg::CNT_W-1:0]);
        end
      end
      plf_pkg::ALU_ADD: begin
        rsp.res = req.a + req.b;
      end
      plf_pkg::ALU_SUB: begin
        rsp.res = req.a - req.b;
      end
      default: begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule
